>>> sv/tnsw_pkg.sv
// ----------------------------------------------------------------------------
// tnsw_pkg
// Shared types and constants of the NewReno send window controller.
// ----------------------------------------------------------------------------
package tnsw_pkg;

  localparam int SEQ_SPACE_DEFAULT  = 2048;
  localparam int MAX_WINDOW_DEFAULT = 64;

  // Depths of the request queue and the result queue.
  localparam int IN_DEPTH  = 2;
  localparam int OUT_DEPTH = 4;

  localparam int IDX_W   = 11;
  localparam int TOTAL_W = 12;
  localparam int WIN_W   = 7;
  localparam int DUP_W   = 8;
  localparam int CFG_IW  = 2;

  localparam logic [TOTAL_W-1:0] BUF_LIMIT   = 12'd2048;
  localparam logic [DUP_W-1:0]   DUP_TRIGGER = 8'd3;
  localparam logic [DUP_W-1:0]   DUP_MAX     = 8'd255;

  // Configuration register indexes.
  localparam logic [CFG_IW-1:0] REG_TOTAL          = 2'd0;
  localparam logic [CFG_IW-1:0] REG_INIT_WINDOW    = 2'd1;
  localparam logic [CFG_IW-1:0] REG_INIT_THRESHOLD = 2'd2;

  typedef struct packed {
    logic                is_ack;
    logic [IDX_W-1:0]    ack_number;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0]    send_index;
    logic                last_of_burst;
  } result_t;

  typedef struct packed {
    logic                write;
    logic [CFG_IW-1:0]   index;
    logic [TOTAL_W-1:0]  data;
  } cfg_t;

  typedef struct packed {
    logic                clearing;
    logic [WIN_W-1:0]    window;
  } status_t;

endpackage

>>> sv/tnsw_fifo.sv
// ----------------------------------------------------------------------------
// tnsw_fifo
// Small register queue used between the front, the engine and the result port.
// ----------------------------------------------------------------------------
module tnsw_fifo #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

>>> sv/tnsw_engine.sv
// ----------------------------------------------------------------------------
// tnsw_engine
// Back end: holds the congestion state and the acked bitmap, applies acks
// and walks the send pointer for ticks.
// ----------------------------------------------------------------------------
module tnsw_engine #(
  parameter int SEQ_SPACE  = tnsw_pkg::SEQ_SPACE_DEFAULT,
  parameter int MAX_WINDOW = tnsw_pkg::MAX_WINDOW_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  tnsw_pkg::cfg_t     cfg,
  input  logic               item_valid,
  input  tnsw_pkg::item_t    item,
  output logic               item_pop,
  output logic               res_push,
  output tnsw_pkg::result_t  res,
  input  logic               res_full,
  output tnsw_pkg::status_t  status
);

  localparam int AW = $clog2(SEQ_SPACE);
  localparam int PW = (AW > tnsw_pkg::TOTAL_W) ? AW : tnsw_pkg::TOTAL_W;
  localparam logic [7:0] MAXW = 8'(MAX_WINDOW);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  function automatic logic [AW-1:0] map_addr(input logic [tnsw_pkg::TOTAL_W-1:0] v);
    logic [PW-1:0] e;
    e = PW'(v);
    return e[AW-1:0];
  endfunction

  function automatic logic [tnsw_pkg::WIN_W-1:0] clamp_win(input logic [7:0] w);
    logic [7:0] c;
    c = (w > MAXW) ? MAXW : w;
    return c[tnsw_pkg::WIN_W-1:0];
  endfunction

  logic [2:0]                     state, state_next;
  logic [AW-1:0]                  clr_addr, clr_addr_next;
  logic [tnsw_pkg::TOTAL_W-1:0]   total, total_next;
  logic [tnsw_pkg::WIN_W-1:0]     window, window_next;
  logic [tnsw_pkg::WIN_W-1:0]     threshold, threshold_next;
  logic [tnsw_pkg::DUP_W-1:0]     dup_count, dup_count_next;
  logic                           in_recovery, in_recovery_next;
  logic [tnsw_pkg::TOTAL_W-1:0]   send_ptr, send_ptr_next;
  logic [tnsw_pkg::IDX_W-1:0]     last_ack, last_ack_next;
  logic                           last_ack_valid, last_ack_valid_next;
  logic [tnsw_pkg::WIN_W-1:0]     sent, sent_next;
  logic                           pend_valid, pend_valid_next;
  logic [tnsw_pkg::IDX_W-1:0]     pend_idx, pend_idx_next;
  logic [tnsw_pkg::IDX_W-1:0]     probe, probe_next;

  logic                           map_mem [SEQ_SPACE];
  logic                           map_rd;
  logic                           mem_we;
  logic [AW-1:0]                  mem_waddr;
  logic                           mem_re;

  logic [tnsw_pkg::TOTAL_W-1:0]   limit;
  logic                           dup;
  logic [tnsw_pkg::DUP_W-1:0]     dup_inc;
  logic [tnsw_pkg::WIN_W-1:0]     half;
  logic [tnsw_pkg::WIN_W-1:0]     new_thr;

  assign limit   = (total > tnsw_pkg::BUF_LIMIT) ? tnsw_pkg::BUF_LIMIT : total;
  assign dup     = last_ack_valid && (item.ack_number == last_ack);
  assign dup_inc = (dup_count < tnsw_pkg::DUP_MAX) ? dup_count + 1'b1 : dup_count;
  assign half    = window >> 1;
  assign new_thr = (half == '0) ? tnsw_pkg::WIN_W'(1) : half;

  assign status.clearing = (state == S_CLEAR);
  assign status.window   = window;

  always_comb begin
    state_next          = state;
    clr_addr_next       = clr_addr;
    total_next          = total;
    window_next         = window;
    threshold_next      = threshold;
    dup_count_next      = dup_count;
    in_recovery_next    = in_recovery;
    send_ptr_next       = send_ptr;
    last_ack_next       = last_ack;
    last_ack_valid_next = last_ack_valid;
    sent_next           = sent;
    pend_valid_next     = pend_valid;
    pend_idx_next       = pend_idx;
    probe_next          = probe;
    item_pop            = 1'b0;
    res_push            = 1'b0;
    res.send_index      = pend_idx;
    res.last_of_burst   = 1'b0;
    mem_we              = 1'b0;
    mem_waddr           = clr_addr;
    mem_re              = 1'b0;

    case (state)
      S_CLEAR: begin
        // One bitmap entry is cleared per cycle after reset.
        mem_we        = 1'b1;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == AW'(SEQ_SPACE - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (item_valid) begin
          item_pop = 1'b1;
          if (item.is_ack) begin
            if (dup) begin
              dup_count_next = dup_inc;
              if (dup_inc == tnsw_pkg::DUP_TRIGGER) begin
                threshold_next   = new_thr;
                window_next      = clamp_win({1'b0, new_thr});
                send_ptr_next    = {1'b0, last_ack} + 1'b1;
                in_recovery_next = 1'b1;
              end else if (dup_inc > tnsw_pkg::DUP_TRIGGER && in_recovery) begin
                window_next = clamp_win({1'b0, window} + 8'd1);
              end
            end else begin
              last_ack_next       = item.ack_number;
              last_ack_valid_next = 1'b1;
              mem_we              = 1'b1;
              mem_waddr           = map_addr({1'b0, item.ack_number});
              dup_count_next      = '0;
              if (in_recovery) begin
                window_next      = clamp_win({1'b0, threshold});
                in_recovery_next = 1'b0;
              end else if (window < threshold) begin
                window_next = clamp_win({window, 1'b0});
              end else begin
                window_next = clamp_win({1'b0, window} + 8'd1);
              end
            end
          end else begin
            sent_next       = '0;
            pend_valid_next = 1'b0;
            state_next      = S_READ;
          end
        end
      end
      S_READ: begin
        if (sent < window && send_ptr < limit) begin
          mem_re        = 1'b1;
          probe_next    = send_ptr[tnsw_pkg::IDX_W-1:0];
          send_ptr_next = send_ptr + 1'b1;
          state_next    = S_EVAL;
        end else begin
          state_next = S_FLUSH;
        end
      end
      S_EVAL: begin
        if (map_rd) begin
          state_next = S_READ;
        end else if (!(pend_valid && res_full)) begin
          // The held index is not the last one, since another follows it.
          res_push        = pend_valid;
          pend_valid_next = 1'b1;
          pend_idx_next   = probe;
          sent_next       = sent + 1'b1;
          state_next      = S_READ;
        end
      end
      S_FLUSH: begin
        if (!pend_valid) begin
          state_next = S_IDLE;
        end else if (!res_full) begin
          res_push          = 1'b1;
          res.last_of_burst = 1'b1;
          pend_valid_next   = 1'b0;
          state_next        = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (cfg.write) begin
      case (cfg.index)
        tnsw_pkg::REG_TOTAL: begin
          total_next = cfg.data;
        end
        tnsw_pkg::REG_INIT_WINDOW: begin
          window_next = clamp_win({1'b0, cfg.data[tnsw_pkg::WIN_W-1:0]});
        end
        tnsw_pkg::REG_INIT_THRESHOLD: begin
          threshold_next = cfg.data[tnsw_pkg::WIN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clr_addr       <= '0;
      total          <= '0;
      window         <= clamp_win(8'd1);
      threshold      <= tnsw_pkg::WIN_W'(32);
      dup_count      <= '0;
      in_recovery    <= 1'b0;
      send_ptr       <= '0;
      last_ack       <= '0;
      last_ack_valid <= 1'b0;
      sent           <= '0;
      pend_valid     <= 1'b0;
    end else begin
      state          <= state_next;
      clr_addr       <= clr_addr_next;
      total          <= total_next;
      window         <= window_next;
      threshold      <= threshold_next;
      dup_count      <= dup_count_next;
      in_recovery    <= in_recovery_next;
      send_ptr       <= send_ptr_next;
      last_ack       <= last_ack_next;
      last_ack_valid <= last_ack_valid_next;
      sent           <= sent_next;
      pend_valid     <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx <= pend_idx_next;
    probe    <= probe_next;
  end

  // Acked bitmap: one write port shared by the clearing pass and acks.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= (state == S_IDLE);
    end
    if (mem_re) begin
      map_rd <= map_mem[map_addr(send_ptr)];
    end
  end

endmodule

>>> sv/tcp_newreno_send_window.sv
// ----------------------------------------------------------------------------
// tcp_newreno_send_window
// NewReno style sender window control: acks update the window, ticks emit
// the packet indices to send.
// ----------------------------------------------------------------------------
//  Channel   Ports                                    Handshake
//  request   kind, ack_number                         push / full
//  result    send_index, last_of_burst                pop / empty
//  config    cfg_index, cfg_data                      cfg_write
//
// An ack is applied as the engine takes it from the head of the request queue.
// A tick is taken from the head, then walks the bitmap with a read of the
// acked bitmap and a check for each entry, then makes the final window and
// total check and pushes the last index.
// After reset the bitmap is cleared one entry per cycle, with full held high.
// A full result queue stalls the tick walk; the request queue keeps taking
// requests meanwhile until it fills.
// ----------------------------------------------------------------------------
module tcp_newreno_send_window #(
  parameter int SEQ_SPACE  = tnsw_pkg::SEQ_SPACE_DEFAULT,
  parameter int MAX_WINDOW = tnsw_pkg::MAX_WINDOW_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic                          kind,
  input  logic [tnsw_pkg::IDX_W-1:0]    ack_number,
  output logic                          empty,
  input  logic                          pop,
  output logic [tnsw_pkg::IDX_W-1:0]    send_index,
  output logic                          last_of_burst,
  input  logic                          cfg_write,
  input  logic [tnsw_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [tnsw_pkg::TOTAL_W-1:0]  cfg_data
);

  tnsw_pkg::item_t   in_item;
  tnsw_pkg::item_t   head_item;
  logic              in_full;
  logic              in_empty;
  logic              item_pop;
  tnsw_pkg::cfg_t    cfg;
  tnsw_pkg::status_t status;
  tnsw_pkg::result_t res;
  tnsw_pkg::result_t out_res;
  logic              res_push;
  logic              res_full;

  // The front classifies a request by its kind before it is queued.
  assign in_item.is_ack     = kind;
  assign in_item.ack_number = ack_number;
  assign full               = in_full || status.clearing;

  assign cfg.write = cfg_write;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  tnsw_fifo #(
    .WIDTH ($bits(tnsw_pkg::item_t)),
    .DEPTH (tnsw_pkg::IN_DEPTH)
  ) u_in_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push && !full),
    .wdata (in_item),
    .full  (in_full),
    .pop   (item_pop),
    .rdata (head_item),
    .empty (in_empty)
  );

  tnsw_engine #(
    .SEQ_SPACE  (SEQ_SPACE),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (!in_empty),
    .item       (head_item),
    .item_pop   (item_pop),
    .res_push   (res_push),
    .res        (res),
    .res_full   (res_full),
    .status     (status)
  );

  tnsw_fifo #(
    .WIDTH ($bits(tnsw_pkg::result_t)),
    .DEPTH (tnsw_pkg::OUT_DEPTH)
  ) u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (out_res),
    .empty (empty)
  );

  assign send_index    = out_res.send_index;
  assign last_of_burst = out_res.last_of_burst;

`ifndef ASSERT_OFF
  a_window_limit: assert property (@(posedge clk) disable iff (rst)
    status.window <= tnsw_pkg::WIN_W'(MAX_WINDOW))
    else $error("congestion window above its limit");

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    status.clearing |-> full)
    else $error("request taken during bitmap clearing");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    item_pop |-> !in_empty && !status.clearing)
    else $error("engine took a request that was not there");
`endif

endmodule

>>> verif/tcp_newreno_send_window_tb.sv
// ----------------------------------------------------------------------------
// tcp_newreno_send_window_tb
// Drives ack and tick requests into the send window controller, predicts
// every packet index each tick should send, and checks the result queue in
// order. Several register settings are covered, from directed corner cases
// to random recovery episodes with random stalls on both sides.
// ----------------------------------------------------------------------------
class send_window_scoreboard;
  localparam int ACK_SPACE = tnsw_pkg::SEQ_SPACE_DEFAULT;
  localparam int WIN_CAP   = tnsw_pkg::MAX_WINDOW_DEFAULT;

  bit [tnsw_pkg::TOTAL_W-1:0] total_packets;
  bit [tnsw_pkg::WIN_W-1:0]   init_window;
  bit [tnsw_pkg::WIN_W-1:0]   init_threshold;
  bit [tnsw_pkg::WIN_W-1:0]   window;
  bit [tnsw_pkg::WIN_W-1:0]   threshold;
  bit [tnsw_pkg::DUP_W-1:0]   dup_count;
  bit                         in_recovery;
  bit [tnsw_pkg::TOTAL_W-1:0] send_ptr;
  bit [tnsw_pkg::IDX_W-1:0]   last_ack;
  bit                         last_ack_valid;
  bit                         acked [ACK_SPACE];
  tnsw_pkg::result_t          pending_sends [$];
  int                         errors;

  function new();
    total_packets  = '0;
    init_window    = tnsw_pkg::WIN_W'(1);
    init_threshold = tnsw_pkg::WIN_W'(32);
    window         = capped(init_window);
    threshold      = init_threshold;
    dup_count      = '0;
    in_recovery    = 1'b0;
    send_ptr       = '0;
    last_ack       = '0;
    last_ack_valid = 1'b0;
    errors         = 0;
  endfunction

  function bit [tnsw_pkg::WIN_W-1:0] capped(int unsigned w);
    return tnsw_pkg::WIN_W'((w > WIN_CAP) ? WIN_CAP : w);
  endfunction

  function int unsigned send_limit();
    return 32'((total_packets > tnsw_pkg::BUF_LIMIT) ? tnsw_pkg::BUF_LIMIT
                                                     : total_packets);
  endfunction

  function int pending();
    return pending_sends.size();
  endfunction

  function void write_reg(logic [tnsw_pkg::CFG_IW-1:0] idx,
                          logic [tnsw_pkg::TOTAL_W-1:0] value);
    case (idx)
      tnsw_pkg::REG_TOTAL: begin
        total_packets = value;
      end
      tnsw_pkg::REG_INIT_WINDOW: begin
        init_window = value[tnsw_pkg::WIN_W-1:0];
        window      = capped(init_window);
      end
      tnsw_pkg::REG_INIT_THRESHOLD: begin
        init_threshold = value[tnsw_pkg::WIN_W-1:0];
        threshold      = init_threshold;
      end
      default: begin
      end
    endcase
  endfunction

  function void apply_ack(bit [tnsw_pkg::IDX_W-1:0] ack);
    int unsigned half;
    if (last_ack_valid && ack == last_ack) begin
      if (dup_count != tnsw_pkg::DUP_MAX) dup_count++;
      if (dup_count == tnsw_pkg::DUP_TRIGGER) begin
        half        = window / 2;
        threshold   = tnsw_pkg::WIN_W'((half < 1) ? 1 : half);
        window      = capped(threshold);
        send_ptr    = {1'b0, last_ack} + 1'b1;
        in_recovery = 1'b1;
      end else if (dup_count > tnsw_pkg::DUP_TRIGGER && in_recovery) begin
        window = capped(window + 1);
      end
    end else begin
      last_ack       = ack;
      last_ack_valid = 1'b1;
      acked[ack]     = 1'b1;
      dup_count      = '0;
      if (in_recovery) begin
        window      = capped(threshold);
        in_recovery = 1'b0;
      end else if (window < threshold) begin
        window = capped(window * 2);
      end else begin
        window = capped(window + 1);
      end
    end
  endfunction

  function void walk_tick();
    int unsigned       sent;
    int unsigned       p;
    int unsigned       burst [$];
    tnsw_pkg::result_t r;
    sent = 0;
    // Acked entries are skipped but still move the pointer.
    while (sent < window && send_ptr < send_limit()) begin
      p        = 32'(send_ptr);
      send_ptr = send_ptr + 1'b1;
      if (!acked[p % ACK_SPACE]) begin
        burst.push_back(p);
        sent++;
      end
    end
    foreach (burst[i]) begin
      r.send_index    = tnsw_pkg::IDX_W'(burst[i]);
      r.last_of_burst = (i == burst.size() - 1);
      pending_sends.push_back(r);
    end
  endfunction

  function void note_request(tnsw_pkg::item_t req);
    if (req.is_ack) apply_ack(req.ack_number);
    else walk_tick();
  endfunction

  function void check_send(logic [tnsw_pkg::IDX_W-1:0] idx, logic last);
    tnsw_pkg::result_t want;
    if (pending_sends.size() == 0) begin
      $display("%0t: send_index expected none, actual %0d (last %0b)", $time, idx, last);
      errors++;
      return;
    end
    want = pending_sends.pop_front();
    if (idx !== want.send_index) begin
      $display("%0t: send_index expected %0d, actual %0d", $time, want.send_index, idx);
      errors++;
    end
    if (last !== want.last_of_burst) begin
      $display("%0t: last_of_burst expected %0b, actual %0b (send_index %0d)",
               $time, want.last_of_burst, last, want.send_index);
      errors++;
    end
  endfunction
endclass

module tcp_newreno_send_window_tb;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_ACK  = 1'b1;
  localparam logic [tnsw_pkg::CFG_IW-1:0] REG_UNUSED = 2'd3;

  // A tick can walk the whole bitmap without sending.
  localparam int SETTLE_CYCLES = 2 * tnsw_pkg::SEQ_SPACE_DEFAULT + 64;
  localparam int STALL_LIMIT   = 20000;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_ITEMS   = 36;

  logic                         clk       = 1'b0;
  logic                         rst       = 1'b1;
  logic                         push      = 1'b0;
  logic                         kind      = 1'b0;
  logic [tnsw_pkg::IDX_W-1:0]   ack_number = '0;
  logic                         pop       = 1'b0;
  logic                         cfg_write = 1'b0;
  logic [tnsw_pkg::CFG_IW-1:0]  cfg_index = '0;
  logic [tnsw_pkg::TOTAL_W-1:0] cfg_data  = '0;
  logic                         full;
  logic                         empty;
  logic [tnsw_pkg::IDX_W-1:0]   send_index;
  logic                         last_of_burst;

  bit                    calm = 1'b0;
  int                    idle_cycles = 0;
  int                    items_sent = 0;
  send_window_scoreboard sb;

  tcp_newreno_send_window u_top (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .kind          (kind),
    .ack_number    (ack_number),
    .empty         (empty),
    .pop           (pop),
    .send_index    (send_index),
    .last_of_burst (last_of_burst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst) pop <= 1'b0;
    else pop <= calm || ($urandom_range(99) >= 25);
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (pop && !empty) sb.check_send(send_index, last_of_burst);
      if ((push && !full) || (pop && !empty)) begin
        idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Returns with push still high so a following request goes out back to back.
  task automatic send_request(input logic k, input logic [tnsw_pkg::IDX_W-1:0] a);
    tnsw_pkg::item_t req;
    while (!calm && $urandom_range(99) < 25) begin
      push <= 1'b0;
      @(posedge clk);
    end
    kind       <= k;
    ack_number <= a;
    push       <= 1'b1;
    do @(posedge clk); while (full !== 1'b0);
    req.is_ack     = k;
    req.ack_number = a;
    sb.note_request(req);
    items_sent++;
  endtask

  task automatic send_tick();
    send_request(KIND_TICK, tnsw_pkg::IDX_W'($urandom_range(2047)));
  endtask

  task automatic send_ack(input logic [tnsw_pkg::IDX_W-1:0] a);
    send_request(KIND_ACK, a);
  endtask

  // The caller lowers cfg_write after its last write.
  task automatic write_reg(input logic [tnsw_pkg::CFG_IW-1:0] idx,
                           input logic [tnsw_pkg::TOTAL_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [tnsw_pkg::IDX_W-1:0] pick_ack();
    int unsigned lim;
    lim = sb.send_limit();
    if (lim == 0 || $urandom_range(4) == 0) return tnsw_pkg::IDX_W'($urandom_range(2047));
    return tnsw_pkg::IDX_W'($urandom_range(lim - 1));
  endfunction

  // Upper data bits are random; only the low seven bits reach the register.
  function automatic logic [tnsw_pkg::TOTAL_W-1:0] window_value();
    logic [tnsw_pkg::WIN_W-1:0] w;
    w = tnsw_pkg::WIN_W'(($urandom_range(9) == 0) ? $urandom_range(127)
                                                  : $urandom_range(1, 64));
    return {5'($urandom_range(31)), w};
  endfunction

  task automatic random_config();
    int roll;
    roll = $urandom_range(9);
    if (roll == 0) write_reg(tnsw_pkg::REG_TOTAL, '0);
    else if (roll == 1)
      write_reg(tnsw_pkg::REG_TOTAL, tnsw_pkg::TOTAL_W'($urandom_range(2048, 4095)));
    else write_reg(tnsw_pkg::REG_TOTAL, tnsw_pkg::TOTAL_W'($urandom_range(8, 400)));
    if ($urandom_range(2) != 0) write_reg(tnsw_pkg::REG_INIT_WINDOW, window_value());
    if ($urandom_range(2) != 0) write_reg(tnsw_pkg::REG_INIT_THRESHOLD, window_value());
    cfg_write <= 1'b0;
  endtask

  task automatic random_phase(input int quota, input bit saturate);
    int                         roll;
    int                         start;
    logic [tnsw_pkg::IDX_W-1:0] dup;
    start = items_sent;
    // A long run of duplicates drives the counter into saturation.
    if (saturate) begin
      if (!sb.last_ack_valid) send_ack(pick_ack());
      dup = sb.last_ack;
      repeat (260 + $urandom_range(12)) begin
        if ($urandom_range(15) == 0) send_tick();
        send_ack(dup);
      end
    end
    while (items_sent - start < quota) begin
      roll = $urandom_range(99);
      if (roll < 30) begin
        repeat ($urandom_range(1, 3)) send_tick();
      end else if (roll < 50) begin
        send_ack(pick_ack());
      end else if (roll < 75) begin
        // Full recovery episode: a new ack at times, three or more duplicates, ticks.
        if (!sb.last_ack_valid || $urandom_range(3) == 0) send_ack(pick_ack());
        dup = sb.last_ack;
        repeat (3 + $urandom_range(4)) begin
          if ($urandom_range(5) == 0) send_tick();
          send_ack(dup);
        end
        repeat ($urandom_range(1, 3)) send_tick();
        if ($urandom_range(1) != 0) send_ack(pick_ack());
      end else if (roll < 85) begin
        // Broken episode: too few duplicates before a new ack.
        dup = sb.last_ack;
        repeat ($urandom_range(1, 2)) send_ack(dup);
        send_ack(pick_ack());
        send_tick();
      end else begin
        send_request(1'($urandom_range(1)), tnsw_pkg::IDX_W'($urandom_range(2047)));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);
    // The bitmap clear holds full high for a while after reset.
    while (full !== 1'b0) @(posedge clk);

    write_reg(tnsw_pkg::REG_TOTAL, 12'd10);
    write_reg(tnsw_pkg::REG_INIT_WINDOW, 12'd1);
    write_reg(tnsw_pkg::REG_INIT_THRESHOLD, 12'd4);
    cfg_write <= 1'b0;
    send_tick();
    send_ack(11'd0);
    send_tick();
    send_ack(11'd2047);
    repeat (4) send_ack(11'd2047);
    // The rewind went past the total, so this tick sends nothing.
    send_tick();
    send_ack(11'd3);
    repeat (5) send_ack(11'd3);
    send_tick();
    send_ack(11'd7);
    send_ack(11'd8);
    send_ack(11'd9);
    // Every entry left below the total is acked; the pointer still walks.
    send_tick();
    drain();

    write_reg(tnsw_pkg::REG_TOTAL, 12'hFFF);
    write_reg(tnsw_pkg::REG_INIT_WINDOW, 12'h07F);
    write_reg(tnsw_pkg::REG_INIT_THRESHOLD, 12'h07F);
    cfg_write <= 1'b0;
    send_tick();
    send_ack(11'd1024);
    send_tick();
    drain();

    write_reg(tnsw_pkg::REG_TOTAL, 12'd20);
    write_reg(tnsw_pkg::REG_INIT_WINDOW, 12'hF80);
    write_reg(tnsw_pkg::REG_INIT_THRESHOLD, 12'd5);
    cfg_write <= 1'b0;
    send_tick();
    send_ack(11'd1500);
    send_tick();
    drain();

    write_reg(tnsw_pkg::REG_TOTAL, 12'd0);
    write_reg(tnsw_pkg::REG_INIT_WINDOW, 12'd0);
    write_reg(tnsw_pkg::REG_INIT_THRESHOLD, 12'd0);
    write_reg(REG_UNUSED, 12'hFFF);
    cfg_write <= 1'b0;
    send_ack(11'h555);
    send_tick();
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      random_config();
      calm = (p == 1);
      random_phase(PHASE_ITEMS, p == 2);
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
